// ----- hw/rtl/brms_pkg.sv -----
// ---------------------------------------------------------------------------
// brms_pkg
// Shared constants and helpers for the banked register file with mode switch
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package brms_pkg;

    localparam int unsigned DEPTH  = 45;
    localparam int unsigned AW     = 6;
    localparam int unsigned DW     = 32;

    typedef logic [AW-1:0] addr_t;
    typedef logic [DW-1:0] word_t;
    typedef logic [4:0]    mode_t;
    typedef logic [2:0]    func_t;

    localparam func_t F_READ   = 3'd0;
    localparam func_t F_WRITE  = 3'd1;
    localparam func_t F_SWITCH = 3'd2;
    localparam func_t F_SWI    = 3'd3;
    localparam func_t F_UND    = 3'd4;
    localparam func_t F_IRQ    = 3'd5;
    localparam func_t F_FIQ    = 3'd6;
    localparam func_t F_RESET  = 3'd7;

    localparam mode_t M_USR = 5'h10;
    localparam mode_t M_FIQ = 5'h11;
    localparam mode_t M_IRQ = 5'h12;
    localparam mode_t M_SVC = 5'h13;
    localparam mode_t M_ABT = 5'h17;
    localparam mode_t M_UND = 5'h1B;
    localparam mode_t M_SYS = 5'h1F;

    localparam addr_t A_R8   = 6'd8;
    localparam addr_t A_R13  = 6'd13;
    localparam addr_t A_R14  = 6'd14;
    localparam addr_t A_R15  = 6'd15;
    localparam addr_t A_CPSR = 6'd16;
    localparam addr_t A_SPSR = 6'd17;
    localparam addr_t A_IRQ  = 6'd18;
    localparam addr_t A_USR  = 6'd26;
    localparam addr_t A_SVC  = 6'd28;
    localparam addr_t A_ABT  = 6'd31;
    localparam addr_t A_UND  = 6'd34;
    localparam addr_t A_FIQL = 6'd37;
    localparam addr_t A_FIQH = 6'd42;

    localparam word_t CPSR_KEEP  = 32'hF000_00C0;
    localparam word_t BIT_I      = 32'h0000_0080;
    localparam word_t BIT_F      = 32'h0000_0040;
    localparam word_t CPSR_RESET = 32'h0000_005F;
    localparam word_t SP_SYS     = 32'h0300_7F00;
    localparam word_t SP_IRQ     = 32'h0300_7FA0;
    localparam word_t SP_SVC     = 32'h0300_7FE0;
    localparam word_t PC_RESET   = 32'h0000_0004;

    function automatic logic mode_ok(input mode_t m);
        return (m == M_USR) || (m == M_FIQ) || (m == M_IRQ) || (m == M_SVC) ||
               (m == M_ABT) || (m == M_UND) || (m == M_SYS);
    endfunction

    function automatic logic is_user(input mode_t m);
        return (m == M_USR) || (m == M_SYS);
    endfunction

    // first slot of the r13/r14/spsr copies of a mode
    function automatic addr_t bank_base(input mode_t m);
        addr_t b;
        case (m)
            M_USR, M_SYS: b = A_USR;
            M_FIQ:        b = A_FIQH;
            M_IRQ:        b = A_IRQ;
            M_SVC:        b = A_SVC;
            M_ABT:        b = A_ABT;
            default:      b = A_UND;
        endcase
        return b;
    endfunction

    // contents of a slot that was not written since reset
    function automatic word_t reset_value(input addr_t a);
        word_t v;
        case (a)
            A_R13:   v = SP_SYS;
            A_R15:   v = PC_RESET;
            A_IRQ:   v = SP_IRQ;
            A_SVC:   v = SP_SVC;
            default: v = '0;
        endcase
        return v;
    endfunction

    function automatic word_t exc_vector(input func_t f);
        word_t v;
        case (f)
            F_SWI:   v = 32'h0000_0008;
            F_UND:   v = 32'h0000_0004;
            F_IRQ:   v = 32'h0000_0018;
            default: v = 32'h0000_001C;
        endcase
        return v;
    endfunction

endpackage

// ----- hw/rtl/banked_register_mode_switch_core.sv -----
// ---------------------------------------------------------------------------
// banked_register_mode_switch_core
// Banked register file with status word, mode switch and exception entry
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

// One item is taken at a time. A mode switch saves the outgoing bank and loads
// the incoming one, with an r8-r12 exchange for each side of it that is FIQ
// mode; an exception entry also reads r15 first and writes r14 and r15 last.
// All of it passes the single read and single write port of the 45-entry
// register memory, which every banked copy goes through. The result sits in an
// output register; the next item can be transferred while it waits.
module banked_register_mode_switch_core (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  brms_pkg::func_t       func,
    input  logic [4:0]            reg_index,
    input  brms_pkg::word_t       write_data,
    input  brms_pkg::mode_t       new_mode,
    input  logic                  save_state,
    output logic                  out_valid,
    input  logic                  out_ready,
    output brms_pkg::word_t       read_data,
    output brms_pkg::word_t       status_word,
    output brms_pkg::word_t       next_fetch,
    output logic                  mode_error
);
    import brms_pkg::*;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_PC   = 4'd1;
    localparam logic [3:0] S_SV   = 4'd2;
    localparam logic [3:0] S_SWPO = 4'd3;
    localparam logic [3:0] S_SVW  = 4'd4;
    localparam logic [3:0] S_SWPI = 4'd5;
    localparam logic [3:0] S_LD   = 4'd6;
    localparam logic [3:0] S_EXC  = 4'd7;
    localparam logic [3:0] S_RD   = 4'd8;
    localparam logic [3:0] S_RDW  = 4'd9;

    localparam logic [2:0] CAP_NONE = 3'd0;
    localparam logic [2:0] CAP_T13  = 3'd1;
    localparam logic [2:0] CAP_T14  = 3'd2;
    localparam logic [2:0] CAP_T17  = 3'd3;
    localparam logic [2:0] CAP_TPC  = 3'd4;
    localparam logic [2:0] CAP_TSW  = 3'd5;

    localparam logic [4:0] SWAP_LAST = 5'd19;

    // logical register indexes as seen on reg_index
    localparam logic [4:0] IDX_CPSR = A_CPSR[4:0];
    localparam logic [4:0] IDX_SPSR = A_SPSR[4:0];

    // register memory
    word_t             ram [DEPTH];
    word_t             ram_q;
    addr_t             ra_q;
    logic              vq_reg;
    logic [DEPTH-1:0]  valid_reg, valid_next;

    logic  re, we;
    addr_t ra, wa;
    word_t wd;
    word_t mem_q;

    logic [3:0] state_reg, state_next;
    logic [4:0] cnt_reg, cnt_next;
    logic [2:0] cap_reg, cap_next;
    func_t      func_reg, func_next;
    logic [4:0] idx_reg, idx_next;
    mode_t      m_reg, m_next;
    logic       save_reg, save_next;
    logic       exc_reg, exc_next;
    logic       err_reg, err_next;
    mode_t      mode_reg, mode_next;
    word_t      cpsr_reg, cpsr_next;
    word_t      fetch_reg, fetch_next;
    word_t      t13_reg, t14_reg, t17_reg, tpc_reg, tsw_reg;

    logic       out_valid_reg, out_valid_next;
    word_t      rd_reg, rd_next;
    word_t      sw_reg, sw_next;
    word_t      nf_reg, nf_next;
    logic       me_reg, me_next;

    logic       in_xfer;
    addr_t      old_base, new_base;
    addr_t      swap_lo, swap_hi;
    word_t      spsr_val;

    assign in_ready = (state_reg == S_IDLE);
    assign in_xfer  = in_valid && in_ready;
    assign mem_q    = vq_reg ? ram_q : reset_value(ra_q);

    assign old_base = bank_base(mode_reg);
    assign new_base = bank_base(m_reg);
    assign swap_lo  = A_R8 + addr_t'(cnt_reg[4:2]);
    assign swap_hi  = A_FIQL + addr_t'(cnt_reg[4:2]);
    // spsr in force after the outgoing bank is saved
    assign spsr_val = is_user(mode_reg) ? cpsr_reg : t17_reg;

    always_comb
    begin
        re             = 1'b0;
        ra             = '0;
        we             = 1'b0;
        wa             = '0;
        wd             = '0;
        cap_next       = CAP_NONE;
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        func_next      = func_reg;
        idx_next       = idx_reg;
        m_next         = m_reg;
        save_next      = save_reg;
        exc_next       = exc_reg;
        err_next       = err_reg;
        mode_next      = mode_reg;
        cpsr_next      = cpsr_reg;
        fetch_next     = fetch_reg;
        valid_next     = valid_reg;
        out_valid_next = out_valid_reg && !out_ready;
        rd_next        = rd_reg;
        sw_next        = sw_reg;
        nf_next        = nf_reg;
        me_next        = me_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (in_xfer)
                begin
                    func_next  = func;
                    idx_next   = reg_index;
                    err_next   = 1'b0;
                    save_next  = 1'b1;
                    exc_next   = 1'b1;
                    cnt_next   = '0;
                    state_next = S_PC;
                    case (func)
                        F_READ:
                            state_next = S_RD;
                        F_WRITE:
                        begin
                            state_next = S_RD;
                            if (reg_index < IDX_CPSR || reg_index == IDX_SPSR)
                            begin
                                we = 1'b1;
                                wa = addr_t'(reg_index);
                                wd = write_data;
                            end
                            else if (reg_index == IDX_CPSR)
                                cpsr_next = (write_data & CPSR_KEEP) | word_t'(mode_reg);
                        end
                        F_SWITCH:
                        begin
                            m_next    = new_mode;
                            save_next = save_state;
                            exc_next  = 1'b0;
                            if (mode_ok(new_mode))
                                state_next = S_SV;
                            else
                            begin
                                err_next   = 1'b1;
                                state_next = S_RD;
                            end
                        end
                        F_SWI:
                            m_next = M_SVC;
                        F_UND:
                            m_next = M_UND;
                        F_IRQ:
                            m_next = M_IRQ;
                        F_FIQ:
                        begin
                            m_next = M_FIQ;
                            if ((cpsr_reg & BIT_F) != '0)
                                state_next = S_RD;
                        end
                        default:
                        begin
                            valid_next = '0;
                            mode_next  = M_SYS;
                            cpsr_next  = CPSR_RESET;
                            fetch_next = '0;
                            state_next = S_RD;
                        end
                    endcase
                end
            end
            S_PC:
            begin
                re         = 1'b1;
                ra         = A_R15;
                cap_next   = CAP_TPC;
                state_next = S_SV;
            end
            S_SV:
            begin
                re       = 1'b1;
                cnt_next = cnt_reg + 5'd1;
                case (cnt_reg)
                    5'd0:
                    begin
                        ra       = A_R13;
                        cap_next = CAP_T13;
                    end
                    5'd1:
                    begin
                        ra       = A_R14;
                        cap_next = CAP_T14;
                    end
                    default:
                    begin
                        ra         = A_SPSR;
                        cap_next   = CAP_T17;
                        cnt_next   = '0;
                        state_next = (mode_reg == M_FIQ) ? S_SWPO : S_SVW;
                    end
                endcase
            end
            S_SWPO, S_SWPI:
            begin
                cnt_next = cnt_reg + 5'd1;
                case (cnt_reg[1:0])
                    2'd0:
                    begin
                        re       = 1'b1;
                        ra       = swap_lo;
                        cap_next = CAP_TSW;
                    end
                    2'd1:
                    begin
                        re = 1'b1;
                        ra = swap_hi;
                    end
                    2'd2:
                    begin
                        we = 1'b1;
                        wa = swap_lo;
                        wd = mem_q;
                    end
                    default:
                    begin
                        we = 1'b1;
                        wa = swap_hi;
                        wd = tsw_reg;
                    end
                endcase
                if (cnt_reg == SWAP_LAST)
                begin
                    cnt_next   = '0;
                    state_next = (state_reg == S_SWPO) ? S_SVW : S_LD;
                end
            end
            S_SVW:
            begin
                we       = 1'b1;
                cnt_next = cnt_reg + 5'd1;
                case (cnt_reg)
                    5'd0:
                    begin
                        wa = old_base;
                        wd = t13_reg;
                    end
                    5'd1:
                    begin
                        wa = old_base + addr_t'(1);
                        wd = t14_reg;
                    end
                    default:
                    begin
                        // user modes have no own spsr: the status word goes there
                        wa         = is_user(mode_reg) ? A_SPSR : old_base + addr_t'(2);
                        wd         = spsr_val;
                        cnt_next   = '0;
                        state_next = (m_reg == M_FIQ) ? S_SWPI : S_LD;
                    end
                endcase
            end
            S_LD:
            begin
                cnt_next = cnt_reg + 5'd1;
                case (cnt_reg)
                    5'd0:
                    begin
                        re = 1'b1;
                        ra = new_base;
                    end
                    5'd1:
                    begin
                        we = 1'b1;
                        wa = A_R13;
                        wd = mem_q;
                    end
                    5'd2:
                    begin
                        re = 1'b1;
                        ra = new_base + addr_t'(1);
                    end
                    5'd3:
                    begin
                        we = 1'b1;
                        wa = A_R14;
                        wd = mem_q;
                    end
                    5'd4:
                    begin
                        re = 1'b1;
                        ra = new_base + addr_t'(2);
                    end
                    default:
                    begin
                        if (!is_user(m_reg))
                        begin
                            we = 1'b1;
                            wa = A_SPSR;
                            wd = save_reg ? cpsr_reg : mem_q;
                        end
                        cpsr_next  = (((m_reg == M_FIQ) ? cpsr_reg : spsr_val) & CPSR_KEEP)
                                     | word_t'(m_reg);
                        mode_next  = m_reg;
                        cnt_next   = '0;
                        state_next = exc_reg ? S_EXC : S_RD;
                    end
                endcase
            end
            S_EXC:
            begin
                we       = 1'b1;
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == 5'd0)
                begin
                    wa = A_R14;
                    wd = (func_reg == F_SWI || func_reg == F_UND) ? tpc_reg - 32'd4 : tpc_reg;
                end
                else
                begin
                    wa         = A_R15;
                    wd         = exc_vector(func_reg) + 32'd4;
                    fetch_next = exc_vector(func_reg);
                    cpsr_next  = cpsr_reg | ((func_reg == F_FIQ) ? (BIT_I | BIT_F) : BIT_I);
                    cnt_next   = '0;
                    state_next = S_RD;
                end
            end
            S_RD:
            begin
                re         = (idx_reg <= IDX_SPSR);
                ra         = addr_t'(idx_reg);
                state_next = S_RDW;
            end
            S_RDW:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    if (idx_reg == IDX_CPSR)
                        rd_next = cpsr_reg;
                    else if (idx_reg > IDX_SPSR)
                        rd_next = '0;
                    else
                        rd_next = mem_q;
                    sw_next    = cpsr_reg;
                    nf_next    = fetch_reg;
                    me_next    = err_reg;
                    state_next = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase

        if (we)
            valid_next[wa] = 1'b1;
    end

    // memory: one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (we)
            ram[wa] <= wd;
        if (re)
        begin
            ram_q <= ram[ra];
            ra_q  <= ra;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vq_reg        <= 1'b0;
            valid_reg     <= '0;
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            cap_reg       <= CAP_NONE;
            mode_reg      <= M_SYS;
            cpsr_reg      <= CPSR_RESET;
            fetch_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (re)
                vq_reg <= valid_reg[ra];
            valid_reg     <= valid_next;
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            cap_reg       <= cap_next;
            mode_reg      <= mode_next;
            cpsr_reg      <= cpsr_next;
            fetch_reg     <= fetch_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers, read data passes the registered memory output and then lands in a temp
    always_ff @(posedge clk)
    begin
        func_reg <= func_next;
        idx_reg  <= idx_next;
        m_reg    <= m_next;
        save_reg <= save_next;
        exc_reg  <= exc_next;
        err_reg  <= err_next;
        rd_reg   <= rd_next;
        sw_reg   <= sw_next;
        nf_reg   <= nf_next;
        me_reg   <= me_next;
        case (cap_reg)
            CAP_T13: t13_reg <= mem_q;
            CAP_T14: t14_reg <= mem_q;
            CAP_T17: t17_reg <= mem_q;
            CAP_TPC: tpc_reg <= mem_q;
            CAP_TSW: tsw_reg <= mem_q;
            default: ;
        endcase
    end

    assign out_valid   = out_valid_reg;
    assign read_data   = rd_reg;
    assign status_word = sw_reg;
    assign next_fetch  = nf_reg;
    assign mode_error  = me_reg;

    a_mode_field: assert property (@(posedge clk) disable iff (!rst_n)
        cpsr_reg[4:0] == mode_reg)
        else $error("status word mode field differs from current mode");

    a_cpsr_form: assert property (@(posedge clk) disable iff (!rst_n)
        (cpsr_reg & ~(CPSR_KEEP | 32'h0000_001F)) == '0)
        else $error("status word holds bits outside flags, masks and mode");

    a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
        !(re && we && (ra == wa)))
        else $error("memory read and write hit the same entry in one cycle");

    a_result_after_read: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RD) |=> (state_reg == S_RDW))
        else $error("final register read not followed by result stage");

endmodule

// ----- test/tb_banked_register_mode_switch_core.sv -----
// ---------------------------------------------------------------------------
// tb_banked_register_mode_switch_core
// Drives register reads and writes, mode switches, exceptions and resets into
// the banked register file and checks every result against a local predictor
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_banked_register_mode_switch_core;

    import brms_pkg::*;

    typedef struct packed {
        func_t      fn;
        logic [4:0] idx;
        word_t      data;
        mode_t      nm;
        logic       save;
    } op_t;

    typedef struct packed {
        word_t rd;
        word_t st;
        word_t nf;
        logic  err;
    } res_t;

    localparam int STALL_LIMIT = 20000;
    localparam logic [4:0] IDX_CPSR = A_CPSR[4:0];
    localparam logic [4:0] IDX_SPSR = A_SPSR[4:0];

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    func_t      func;
    logic [4:0] reg_index;
    word_t      write_data;
    mode_t      new_mode;
    logic       save_state;
    logic       out_valid;
    logic       out_ready;
    word_t      read_data;
    word_t      status_word;
    word_t      next_fetch;
    logic       mode_error;

    op_t   pending_ops[$];
    res_t  expected_res[$];
    word_t regs[45];
    mode_t cur_mode;
    word_t fetch_addr;
    int    fail_count;
    int    op_count;
    int    res_count;
    int    switch_count;
    int    exc_count;
    int    idle_cycles;
    bit    calm;
    bit    inputs_done;

    banked_register_mode_switch_core dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .func        (func),
        .reg_index   (reg_index),
        .write_data  (write_data),
        .new_mode    (new_mode),
        .save_state  (save_state),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .read_data   (read_data),
        .status_word (status_word),
        .next_fetch  (next_fetch),
        .mode_error  (mode_error)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic bit mode_valid(mode_t m);
        return m == M_USR || m == M_FIQ || m == M_IRQ || m == M_SVC ||
               m == M_ABT || m == M_UND || m == M_SYS;
    endfunction

    function automatic int unsigned banked_slot(mode_t m);
        if (m == M_IRQ) return A_IRQ;
        if (m == M_SVC) return A_SVC;
        if (m == M_ABT) return A_ABT;
        return A_UND;
    endfunction

    function automatic void reset_regs();
        foreach (regs[i]) regs[i] = '0;
        cur_mode = M_SYS;
        regs[A_R13] = SP_SYS;
        regs[A_IRQ] = SP_IRQ;
        regs[A_SVC] = SP_SVC;
        regs[A_CPSR] = CPSR_RESET;
        regs[A_R15] = PC_RESET;
        fetch_addr = '0;
    endfunction

    function automatic void exchange_fiq_low();
        word_t t;
        for (int i = 0; i < 5; i++)
        begin
            t = regs[8 + i];
            regs[8 + i] = regs[A_FIQL + i];
            regs[A_FIQL + i] = t;
        end
    endfunction

    function automatic void change_mode(mode_t m, bit save);
        word_t cpsr;
        word_t spsr;
        int unsigned b;
        if (cur_mode == M_USR || cur_mode == M_SYS)
        begin
            regs[A_USR] = regs[13];
            regs[A_USR + 1] = regs[14];
            regs[A_SPSR] = regs[A_CPSR];
        end
        else if (cur_mode == M_FIQ)
        begin
            exchange_fiq_low();
            regs[A_FIQL + 5] = regs[13];
            regs[A_FIQL + 6] = regs[14];
            regs[A_FIQL + 7] = regs[A_SPSR];
        end
        else
        begin
            b = banked_slot(cur_mode);
            regs[b] = regs[13];
            regs[b + 1] = regs[14];
            regs[b + 2] = regs[A_SPSR];
        end
        cpsr = regs[A_CPSR];
        spsr = regs[A_SPSR];
        if (m == M_USR || m == M_SYS)
        begin
            regs[13] = regs[A_USR];
            regs[14] = regs[A_USR + 1];
            regs[A_CPSR] = spsr;
        end
        else if (m == M_FIQ)
        begin
            exchange_fiq_low();
            regs[13] = regs[A_FIQL + 5];
            regs[14] = regs[A_FIQL + 6];
            regs[A_SPSR] = save ? cpsr : regs[A_FIQL + 7];
        end
        else
        begin
            b = banked_slot(m);
            regs[13] = regs[b];
            regs[14] = regs[b + 1];
            regs[A_CPSR] = spsr;
            regs[A_SPSR] = save ? cpsr : regs[b + 2];
        end
        cur_mode = m;
        regs[A_CPSR] = (regs[A_CPSR] & CPSR_KEEP) | word_t'(cur_mode);
    endfunction

    function automatic void enter_exception(mode_t m, word_t link_sub, word_t vec,
                                            word_t mask);
        word_t pc;
        pc = regs[15];
        change_mode(m, 1'b1);
        regs[14] = pc - link_sub;
        regs[A_CPSR] |= mask;
        fetch_addr = vec;
        regs[15] = vec + 32'd4;
        exc_count++;
    endfunction

    function automatic res_t predict_result(op_t op);
        res_t r;
        r.err = 1'b0;
        case (op.fn)
            F_WRITE:
                if (op.idx < IDX_CPSR || op.idx == IDX_SPSR)
                    regs[op.idx] = op.data;
                else if (op.idx == IDX_CPSR)
                    regs[A_CPSR] = (op.data & CPSR_KEEP) | word_t'(cur_mode);
            F_SWITCH:
                if (mode_valid(op.nm))
                begin
                    change_mode(op.nm, op.save);
                    switch_count++;
                end
                else
                    r.err = 1'b1;
            F_SWI: enter_exception(M_SVC, 32'd4, 32'h08, BIT_I);
            F_UND: enter_exception(M_UND, 32'd4, 32'h04, BIT_I);
            F_IRQ: enter_exception(M_IRQ, 32'd0, 32'h18, BIT_I);
            F_FIQ:
                if ((regs[A_CPSR] & BIT_F) == '0)
                    enter_exception(M_FIQ, 32'd0, 32'h1C, BIT_I | BIT_F);
            F_RESET: reset_regs();
            default: ;
        endcase
        r.rd = (op.idx <= IDX_SPSR) ? regs[op.idx] : '0;
        r.st = regs[A_CPSR];
        r.nf = fetch_addr;
        return r;
    endfunction

    function automatic op_t make_op(func_t fn, logic [4:0] idx, word_t data, mode_t nm,
                                    logic save);
        op_t op;
        op.fn = fn;
        op.idx = idx;
        op.data = data;
        op.nm = nm;
        op.save = save;
        return op;
    endfunction

    function automatic mode_t pick_mode();
        mode_t legal[7] = '{M_USR, M_FIQ, M_IRQ, M_SVC, M_ABT, M_UND, M_SYS};
        if ($urandom_range(0, 9) == 0) return mode_t'($urandom);
        return legal[$urandom_range(0, 6)];
    endfunction

    // mostly well-formed traffic: writes and reads around switches and exceptions
    function automatic op_t random_op();
        op_t op;
        int unsigned k;
        op = make_op(F_READ, 5'($urandom_range(0, 17)), $urandom, mode_t'($urandom),
                     1'($urandom));
        if ($urandom_range(0, 19) == 0) op.idx = 5'($urandom);
        k = $urandom_range(0, 99);
        if (k < 30) op.fn = F_WRITE;
        else if (k < 55) op.fn = F_READ;
        else if (k < 75)
        begin
            op.fn = F_SWITCH;
            op.nm = pick_mode();
        end
        else if (k < 80) op.fn = F_SWI;
        else if (k < 84) op.fn = F_UND;
        else if (k < 88) op.fn = F_IRQ;
        else if (k < 95) op.fn = F_FIQ;
        else if (k < 97) op.fn = F_RESET;
        else
        begin
            // clear the F bit so a later fiq entry is taken
            op.fn = F_WRITE;
            op.idx = IDX_CPSR;
            op.data = $urandom & ~BIT_F;
        end
        return op;
    endfunction

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            func <= F_READ;
            reg_index <= '0;
            write_data <= '0;
            new_mode <= '0;
            save_state <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                expected_res.push_back(predict_result(
                    make_op(func, reg_index, write_data, new_mode, save_state)));
                op_count++;
            end
            if (!in_valid || in_ready)
            begin
                if (pending_ops.size() > 0 && (calm || $urandom_range(0, 99) >= 38))
                begin
                    op_t op;
                    op = pending_ops.pop_front();
                    in_valid <= 1'b1;
                    func <= op.fn;
                    reg_index <= op.idx;
                    write_data <= op.data;
                    new_mode <= op.nm;
                    save_state <= op.save;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (out_valid && out_ready)
            begin
                res_count++;
                if (expected_res.size() == 0)
                begin
                    $error("result with nothing expected");
                    fail_count++;
                end
                else
                begin
                    res_t e;
                    e = expected_res.pop_front();
                    if (read_data !== e.rd)
                    begin
                        $error("read_data expected %h got %h", e.rd, read_data);
                        fail_count++;
                    end
                    if (status_word !== e.st)
                    begin
                        $error("status_word expected %h got %h", e.st, status_word);
                        fail_count++;
                    end
                    if (next_fetch !== e.nf)
                    begin
                        $error("next_fetch expected %h got %h", e.nf, next_fetch);
                        fail_count++;
                    end
                    if (mode_error !== e.err)
                    begin
                        $error("mode_error expected %b got %b", e.err, mode_error);
                        fail_count++;
                    end
                end
            end
            out_ready <= calm || ($urandom_range(0, 99) >= 38);
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > STALL_LIMIT)
        begin
            $display("FAIL banked_register_mode_switch_core");
            $finish;
        end
    end

    initial
    begin
        mode_t all_modes[7] = '{M_USR, M_FIQ, M_IRQ, M_SVC, M_ABT, M_UND, M_SYS};
        fail_count = 0;
        op_count = 0;
        res_count = 0;
        switch_count = 0;
        exc_count = 0;
        idle_cycles = 0;
        calm = 1'b0;
        inputs_done = 1'b0;
        reset_regs();
        rst_n = 1'b0;
        in_valid = 1'b0;
        func = F_READ;
        reg_index = '0;
        write_data = '0;
        new_mode = '0;
        save_state = 1'b0;
        out_ready = 1'b0;

        // directed: extremes, every func and the special cases
        pending_ops.push_back(make_op(F_READ, 5'd13, '0, '0, 1'b0));
        pending_ops.push_back(make_op(F_WRITE, 5'd0, 32'hFFFF_FFFF, '0, 1'b0));
        pending_ops.push_back(make_op(F_WRITE, 5'd15, 32'h1234_5678, '0, 1'b0));
        pending_ops.push_back(make_op(F_WRITE, IDX_CPSR, 32'hFFFF_FFFF, '0, 1'b0));
        pending_ops.push_back(make_op(F_WRITE, IDX_SPSR, 32'hA5A5_5A5A, '0, 1'b0));
        pending_ops.push_back(make_op(F_WRITE, 5'd31, 32'hFFFF_FFFF, '0, 1'b0));
        pending_ops.push_back(make_op(F_READ, 5'd31, '0, '0, 1'b0));
        pending_ops.push_back(make_op(F_FIQ, 5'd14, '0, '0, 1'b0));
        pending_ops.push_back(make_op(F_IRQ, 5'd14, '0, '0, 1'b0));
        pending_ops.push_back(make_op(F_WRITE, 5'd9, 32'hDEAD_BEEF, '0, 1'b0));
        pending_ops.push_back(make_op(F_SWITCH, 5'd17, '0, 5'h00, 1'b1));
        pending_ops.push_back(make_op(F_SWITCH, 5'd17, '0, 5'h1E, 1'b0));
        pending_ops.push_back(make_op(F_SWITCH, 5'd16, '0, M_SYS, 1'b1));
        pending_ops.push_back(make_op(F_WRITE, IDX_CPSR, 32'h0000_0000, '0, 1'b0));
        pending_ops.push_back(make_op(F_FIQ, 5'd9, '0, '0, 1'b0));
        pending_ops.push_back(make_op(F_WRITE, 5'd9, 32'h0BAD_F00D, '0, 1'b0));
        pending_ops.push_back(make_op(F_SWITCH, 5'd9, '0, M_USR, 1'b0));
        pending_ops.push_back(make_op(F_SWI, 5'd14, '0, '0, 1'b0));
        pending_ops.push_back(make_op(F_UND, 5'd17, '0, '0, 1'b0));
        foreach (all_modes[i])
            pending_ops.push_back(make_op(F_SWITCH, 5'd17, '0, all_modes[i], 1'(i)));
        pending_ops.push_back(make_op(F_RESET, 5'd13, '0, '0, 1'b0));

        for (int i = 0; i < 880; i++)
            pending_ops.push_back(random_op());

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        fork
            begin
                // a stretch with no idling in the middle of the run
                wait (op_count >= 400);
                calm = 1'b1;
                wait (op_count >= 550);
                calm = 1'b0;
            end
        join_none

        wait (pending_ops.size() == 0 && !in_valid && expected_res.size() == 0);
        repeat (60) @(posedge clk);
        $display("covered %0d items: %0d mode switches, %0d exception entries, %0d results",
                 op_count, switch_count, exc_count, res_count);
        if (fail_count == 0 && expected_res.size() == 0)
            $display("PASS banked_register_mode_switch_core");
        else
            $display("FAIL banked_register_mode_switch_core");
        $finish;
    end

endmodule

// ----- filelist.f -----
hw/rtl/brms_pkg.sv
hw/rtl/banked_register_mode_switch_core.sv
test/tb_banked_register_mode_switch_core.sv
